// File: src/lags_pkg.sv
package lags_pkg;

  // Grid size
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  // Derived widths
  localparam int COL_AW = $clog2(MAX_COLUMNS);      // column index
  localparam int ROW_AW = $clog2(MAX_ROWS);         // row index / memory address
  localparam int CFG_W  = 7;                        // in-use count registers
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);     // row sweep counter

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

  // Life rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  typedef logic [MAX_COLUMNS-1:0] row_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_STEP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_STEP,
    ST_RESP
  } state_t;

  // Memory write request
  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    row_t              mask;
    row_t              data;
  } wr_req_t;

endpackage

// File: src/lags_grid_mem.sv
module lags_grid_mem
  import lags_pkg::*;
(
  input  logic              clk,
  input  wr_req_t           wr,
  input  logic [ROW_AW-1:0] rd_addr,
  output row_t              rd_data
);

  row_t mem_q [MAX_ROWS];
  row_t rd_data_r;

  // Write with per-cell enable
  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        if (wr.mask[i]) begin
          mem_q[wr.addr][i] <= wr.data[i];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem_q[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/lags_row_alu.sv
module lags_row_alu
  import lags_pkg::*;
(
  input  row_t above,
  input  row_t center,
  input  row_t below,
  output row_t next_row
);

  logic [MAX_COLUMNS+1:0] a_p;
  logic [MAX_COLUMNS+1:0] m_p;
  logic [MAX_COLUMNS+1:0] b_p;
  logic [3:0]             nbr [MAX_COLUMNS];

  // Pad with dead cells so the edge columns see zero outside
  assign a_p = {1'b0, above, 1'b0};
  assign m_p = {1'b0, center, 1'b0};
  assign b_p = {1'b0, below, 1'b0};

  // Count neighbors and apply B3/S23 per cell
  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      nbr[c] = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2]) +
               4'(m_p[c]) + 4'(m_p[c+2]) +
               4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
      next_row[c] = (nbr[c] == BIRTH_COUNT) || (center[c] && (nbr[c] == SURVIVE_LOW));
    end
  end

endmodule

// File: src/life_automaton_grid_step_unit.sv
// Life grid step unit: a 64 x 64 cell grid under rule B3/S23.
// Input channel (in_valid / in_stall) carries one command per transfer:
// write a cell, read a cell, clear the in-use area, or step one generation.
// Output channel (out_valid / out_stall) returns one out_read_cell per
// command: the cell for a read, 0 otherwise.
// Configuration: cfg_we with cfg_index 0 sets columns in use, 1 rows in use.
// A write goes straight to its result; a read waits on the memory read,
// and a clear passes over all MAX_ROWS rows. The grid memory has one
// read and one write port; a step sweeps it once, one row per cycle, and
// a row-wide neighbor unit computes each new row.
// One command is in flight at a time; in_stall is high until its result is
// in the output register. That register lets the next command be taken
// while a result waits on out_stall; a finished command holds until the
// output register is free. The next command can be taken after the load.
// Reset (rst_n low, synchronous) clears control state, sets both in-use
// counts to 64, then runs a fill pass over all MAX_ROWS (64) rows that sets
// every cell alive; in_stall is high during the fill. Configuration writes
// are taken at any time.
module life_automaton_grid_step_unit
  import lags_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic [COL_AW-1:0]    in_column,
  input  logic [ROW_AW-1:0]    in_row,
  input  logic                 in_cell_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_read_cell,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  cols_r, rows_r;
  mode_t             mode_r, mode_nxt;
  logic [COL_AW-1:0] col_r, col_nxt;
  logic              inside_r, inside_nxt;
  logic              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_r, out_cell_nxt;
  row_t              prev_r, cur_r;

  logic [CFG_W-1:0]  nc, nr;
  logic              in_xfer, out_xfer, out_free, in_inside;
  row_t              use_mask, int_mask, rd_data, alu_row;
  logic [ROW_AW-1:0] rd_addr;
  logic [CNT_W-1:0]  cnt_m1;
  wr_req_t           wr;

  // Effective in-use counts, capped at the grid size
  assign nc = (cols_r > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cols_r;
  assign nr = (rows_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_inside = (CFG_W'(in_column) < nc) && (CFG_W'(in_row) < nr);
  assign cnt_m1    = cnt_r - CNT_W'(1);

  // Column masks: in-use area and interior
  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      use_mask[c] = CFG_W'(c) < nc;
      int_mask[c] = (c >= 1) && (CFG_W'(c + 1) < nc);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_W'(MAX_COLUMNS);
      rows_r <= CFG_W'(MAX_ROWS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: cols_r <= cfg_wdata;
        REG_ROWS:    rows_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (cnt_r == CNT_W'(MAX_ROWS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (mode_t'(in_mode))
            MODE_WRITE: state_nxt = ST_RESP;
            MODE_READ:  state_nxt = ST_READ;
            MODE_CLEAR: state_nxt = ST_CLEAR;
            MODE_STEP:  state_nxt = ST_STEP;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_RESP;
      ST_CLEAR: begin
        if (cnt_r == CNT_W'(MAX_ROWS - 1)) state_nxt = ST_RESP;
      end
      ST_STEP: begin
        if (cnt_r == CNT_W'(MAX_ROWS)) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: counter, command capture, memory access, result
  always_comb begin
    cnt_nxt       = '0;
    mode_nxt      = mode_r;
    col_nxt       = col_r;
    inside_nxt    = inside_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    out_cell_nxt  = out_cell_r;
    rd_addr       = in_row;
    wr.en         = 1'b0;
    wr.addr       = cnt_r[ROW_AW-1:0];
    wr.mask       = '0;
    wr.data       = '0;
    case (state_r)
      ST_FILL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        wr.en   = 1'b1;
        wr.mask = '1;
        wr.data = '1;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt   = mode_t'(in_mode);
          col_nxt    = in_column;
          inside_nxt = in_inside;
          res_nxt    = 1'b0;
          if (mode_t'(in_mode) == MODE_WRITE && in_inside) begin
            wr.en   = 1'b1;
            wr.addr = in_row;
            wr.mask = row_t'(1) << in_column;
            wr.data = {MAX_COLUMNS{in_cell_value}};
          end
        end
      end
      ST_READ: begin
        res_nxt = inside_r && rd_data[col_r];
      end
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        wr.en   = CFG_W'(cnt_r) < nr;
        wr.mask = use_mask;
      end
      ST_STEP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        rd_addr = cnt_r[ROW_AW-1:0];
        // rd_data holds row cnt-1; update row cnt-2
        wr.en   = (cnt_r >= CNT_W'(3)) && (CFG_W'(cnt_m1) < nr);
        wr.addr = ROW_AW'(cnt_r - CNT_W'(2));
        wr.mask = int_mask;
        wr.data = alu_row;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    col_r      <= col_nxt;
    inside_r   <= inside_nxt;
    res_r      <= res_nxt;
    out_cell_r <= out_cell_nxt;
    // Advance the three-row window during a step
    if (state_r == ST_STEP) begin
      cur_r  <= rd_data;
      prev_r <= cur_r;
    end
  end

  lags_grid_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lags_row_alu u_alu (
    .above    (prev_r),
    .center   (cur_r),
    .below    (rd_data),
    .next_row (alu_row)
  );

  assign out_valid     = out_valid_r;
  assign out_read_cell = out_cell_r;

`ifndef SYNTH
  // A finished command never overwrites a result still waiting on the receiver
  a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_valid_r && out_stall) |=> (state_r == ST_RESP))
    else $error("result loaded over a pending output");

  // Commands other than a read return a dead cell
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_free && mode_r != MODE_READ)
      |=> (out_valid && !out_read_cell))
    else $error("non-read command returned a live cell");

  // A step never rewrites the border rows of the in-use area
  a_step_border: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && wr.en)
      |-> (wr.addr != '0 && (CFG_W'(wr.addr) + CFG_W'(1)) < nr))
    else $error("step wrote a border row");
`endif

endmodule
